### rtl/core/fat12_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT12 cluster table engine package
// Shared widths, codes, state type and entry addressing helpers.
// ----------------------------------------------------------------------------
package fat12_pkg;

    localparam int TABLE_BYTES = 6144;
    localparam int BANK_DEPTH  = (TABLE_BYTES + 1) / 2;
    localparam int ROW_W       = $clog2(BANK_DEPTH);

    localparam int ACTION_W    = 3;
    localparam int BYTE_ADDR_W = 13;
    localparam int BYTE_W      = 8;
    localparam int CLUSTER_W   = 12;
    localparam int ENTRY_W     = 12;
    localparam int LIMIT_W     = 13;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 24;

    localparam logic [BYTE_ADDR_W-1:0] TABLE_END        = 13'(TABLE_BYTES);
    localparam logic [ENTRY_W-1:0]     EOC_LOW          = 12'hFF8;
    localparam logic [CLUSTER_W-1:0]   SEARCH_FIRST_RST = 12'd3;
    localparam logic [LIMIT_W-1:0]     SEARCH_LIMIT_RST = 13'd2304;
    localparam logic [LIMIT_W-1:0]     CLUSTER_SPAN     = 13'd4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_BYTE   = 3'd0,
        ACT_READ_BYTE   = 3'd1,
        ACT_READ_ENTRY  = 3'd2,
        ACT_WRITE_ENTRY = 3'd3,
        ACT_FIND_FREE   = 3'd4
    } action_t;

    typedef enum logic {
        CFG_SEARCH_FIRST = 1'b0,
        CFG_SEARCH_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Bytes are split over two banks by address parity, so the two bytes of
    // an entry always sit in different banks and are read together in one read.
    typedef struct packed {
        logic [ROW_W-1:0] row_even;
        logic [ROW_W-1:0] row_odd;
        logic             odd_start;
        logic             lo_ok;
        logic             hi_ok;
    } pair_loc_t;

    function automatic pair_loc_t pair_locate(input logic [CLUSTER_W-1:0] c);
        logic [BYTE_ADDR_W:0] off;
        logic [BYTE_ADDR_W:0] off_hi;
        pair_loc_t            loc;
        off           = {2'b00, c} + {3'b000, c[CLUSTER_W-1:1]};
        off_hi        = off + 14'd1;
        loc.odd_start = off[0];
        loc.row_odd   = off[ROW_W:1];
        loc.row_even  = off_hi[ROW_W:1];
        loc.lo_ok     = off < 14'(TABLE_BYTES);
        loc.hi_ok     = off_hi < 14'(TABLE_BYTES);
        return loc;
    endfunction

    function automatic logic [ENTRY_W-1:0] entry_of(input logic [BYTE_W-1:0] lo,
                                                    input logic [BYTE_W-1:0] hi,
                                                    input logic odd_cluster);
        logic [2*BYTE_W-1:0] pair;
        pair = {hi, lo};
        return odd_cluster ? pair[15:4] : pair[11:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/fat12_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fat12_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/fat12_cluster_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte and entry requests pass through an access or done state and load their result
// once the output slot is free; a new request is taken only back in idle. Both bytes of an
// entry come from two parity banks in one read; the write-back is made in the access state.
// Find free examines the clusters of its window one per cycle from the first cluster and
// stops at a free entry or at the end of window or table; an empty window is not searched.
// Synchronous reset clears control state, sets the search window to 3 and 2304, keeps the table.
// ----------------------------------------------------------------------------
// FAT12 cluster table engine
// Packed FAT12 allocation table with byte, entry and free-search requests.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine
    import fat12_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Request: byte_address, byte_value, cluster, entry_value (low bit up).
    input  logic [S_DATA_W-1:0] s_tdata,
    // Request: action.
    input  logic [ACTION_W-1:0] s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // Result: byte_data, entry_data, end_of_chain, found_free (low bit up).
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    state_t state_reg, state_next;

    logic [CLUSTER_W-1:0] search_first_reg;
    logic [LIMIT_W-1:0]   search_limit_reg;

    action_t              act_reg;
    logic [ENTRY_W-1:0]   evalue_reg;
    logic [CLUSTER_W-1:0] cur_reg;
    logic                 odd_start_reg;
    logic                 lo_ok_reg;
    logic                 hi_ok_reg;
    logic [ROW_W-1:0]     row_even_reg;
    logic [ROW_W-1:0]     row_odd_reg;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [ENTRY_W-1:0]   out_entry_reg;
    logic                 out_eoc_reg;
    logic                 out_found_reg;

    action_t              in_action;
    logic [BYTE_ADDR_W-1:0] in_byte_addr;
    logic [BYTE_W-1:0]    in_byte_value;
    logic [CLUSTER_W-1:0] in_cluster;
    logic [ENTRY_W-1:0]   in_entry_value;
    logic [ROW_W-1:0]     in_row;
    logic                 in_byte_ok;
    logic                 in_acc;
    logic                 in_byte_req;

    logic [CLUSTER_W-1:0] loc_cluster;
    pair_loc_t            loc;

    logic                 issue;
    logic                 iss_odd_start;
    logic                 iss_lo_ok;
    logic                 iss_hi_ok;
    logic [ROW_W-1:0]     iss_row_even;
    logic [ROW_W-1:0]     iss_row_odd;

    logic [BYTE_W-1:0]    even_rd_data;
    logic [BYTE_W-1:0]    odd_rd_data;
    logic                 even_we;
    logic                 odd_we;
    logic [ROW_W-1:0]     even_waddr;
    logic [ROW_W-1:0]     odd_waddr;
    logic [BYTE_W-1:0]    even_wdata;
    logic [BYTE_W-1:0]    odd_wdata;

    logic [BYTE_W-1:0]    lo_old;
    logic [BYTE_W-1:0]    hi_old;
    logic [BYTE_W-1:0]    lo_new;
    logic [BYTE_W-1:0]    hi_new;
    logic [BYTE_W-1:0]    byte_rd;
    logic [ENTRY_W-1:0]   entry_rd;

    logic [LIMIT_W-1:0]   next_cluster;
    logic                 next_in_window;
    logic                 start_ok;
    logic                 search_step;
    logic                 search_end;
    logic                 search_hit;
    logic                 slot_free;

    logic                 res_load;
    logic [BYTE_W-1:0]    res_byte;
    logic [ENTRY_W-1:0]   res_entry;
    logic                 res_eoc;
    logic                 res_found;

    assign in_action      = action_t'(s_tuser);
    assign in_byte_addr   = s_tdata[12:0];
    assign in_byte_value  = s_tdata[20:13];
    assign in_cluster     = s_tdata[32:21];
    assign in_entry_value = s_tdata[44:33];
    assign in_row         = in_byte_addr[ROW_W:1];
    assign in_byte_ok     = in_byte_addr < TABLE_END;
    assign in_byte_req    = (in_action == ACT_LOAD_BYTE) || (in_action == ACT_READ_BYTE);

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        if (state_reg == ST_SEARCH) begin
            loc_cluster = cur_reg + 12'd1;
        end else if (in_action == ACT_FIND_FREE) begin
            loc_cluster = search_first_reg;
        end else begin
            loc_cluster = in_cluster;
        end
        loc = pair_locate(loc_cluster);
    end

    always_comb begin
        if (state_reg == ST_IDLE && in_byte_req) begin
            iss_odd_start = in_byte_addr[0];
            iss_lo_ok     = in_byte_ok;
            iss_hi_ok     = 1'b0;
            iss_row_even  = in_row;
            iss_row_odd   = in_row;
        end else begin
            iss_odd_start = loc.odd_start;
            iss_lo_ok     = loc.lo_ok;
            iss_hi_ok     = loc.hi_ok;
            iss_row_even  = loc.row_even;
            iss_row_odd   = loc.row_odd;
        end
    end

    always_comb begin
        lo_old   = lo_ok_reg ? (odd_start_reg ? odd_rd_data : even_rd_data) : '0;
        hi_old   = hi_ok_reg ? (odd_start_reg ? even_rd_data : odd_rd_data) : '0;
        byte_rd  = lo_old;
        entry_rd = entry_of(lo_old, hi_old, cur_reg[0]);
        if (cur_reg[0]) begin
            lo_new = {evalue_reg[3:0], lo_old[3:0]};
            hi_new = evalue_reg[11:4];
        end else begin
            lo_new = evalue_reg[7:0];
            hi_new = {hi_old[7:4], evalue_reg[11:8]};
        end
    end

    assign next_cluster   = {1'b0, cur_reg} + 13'd1;
    assign next_in_window = (next_cluster < search_limit_reg) && (next_cluster < CLUSTER_SPAN);
    assign start_ok       = {1'b0, search_first_reg} < search_limit_reg;
    assign search_hit     = hi_ok_reg && (entry_rd == '0);
    assign search_end     = !hi_ok_reg || (entry_rd == '0) || !next_in_window;
    assign search_step    = (state_reg == ST_SEARCH) && !search_end;
    assign issue          = in_acc || search_step;

    always_comb begin
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_waddr = in_row;
        odd_waddr  = in_row;
        even_wdata = in_byte_value;
        odd_wdata  = in_byte_value;
        if (in_acc && in_action == ACT_LOAD_BYTE && in_byte_ok) begin
            odd_we  = in_byte_addr[0];
            even_we = !in_byte_addr[0];
        end else if (state_reg == ST_ACCESS && act_reg == ACT_WRITE_ENTRY && slot_free) begin
            even_we    = odd_start_reg ? hi_ok_reg : lo_ok_reg;
            odd_we     = odd_start_reg ? lo_ok_reg : hi_ok_reg;
            even_waddr = row_even_reg;
            odd_waddr  = row_odd_reg;
            even_wdata = odd_start_reg ? hi_new : lo_new;
            odd_wdata  = odd_start_reg ? lo_new : hi_new;
        end
    end

    fat12_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .aclk    (aclk),
        .wr_en   (even_we),
        .wr_addr (even_waddr),
        .wr_data (even_wdata),
        .rd_en   (issue),
        .rd_addr (iss_row_even),
        .rd_data (even_rd_data)
    );

    fat12_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .aclk    (aclk),
        .wr_en   (odd_we),
        .wr_addr (odd_waddr),
        .wr_data (odd_wdata),
        .rd_en   (issue),
        .rd_addr (iss_row_odd),
        .rd_data (odd_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_action)
                        ACT_READ_BYTE,
                        ACT_READ_ENTRY,
                        ACT_WRITE_ENTRY: state_next = ST_ACCESS;
                        ACT_FIND_FREE:   state_next = start_ok ? ST_SEARCH : ST_DONE;
                        default:         state_next = ST_DONE;
                    endcase
                end
            end
            ST_ACCESS: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (search_end && slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res_load  = 1'b0;
        res_byte  = '0;
        res_entry = '0;
        res_eoc   = 1'b0;
        res_found = 1'b0;
        unique case (state_reg)
            ST_ACCESS: begin
                res_load = slot_free;
                if (act_reg == ACT_READ_BYTE) begin
                    res_byte = byte_rd;
                end else if (act_reg == ACT_READ_ENTRY) begin
                    res_entry = entry_rd;
                    res_eoc   = (entry_rd == '0) || (entry_rd >= EOC_LOW);
                end
            end
            ST_SEARCH: begin
                res_load  = search_end && slot_free;
                res_found = search_hit;
                res_entry = search_hit ? cur_reg : '0;
            end
            ST_DONE: begin
                res_load = slot_free;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            search_first_reg <= SEARCH_FIRST_RST;
            search_limit_reg <= SEARCH_LIMIT_RST;
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SEARCH_FIRST: search_first_reg <= cfg_wdata[CLUSTER_W-1:0];
                    CFG_SEARCH_LIMIT: search_limit_reg <= cfg_wdata;
                    default:          search_limit_reg <= search_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            act_reg    <= in_action;
            evalue_reg <= in_entry_value;
        end
        if (issue) begin
            cur_reg       <= loc_cluster;
            odd_start_reg <= iss_odd_start;
            lo_ok_reg     <= iss_lo_ok;
            hi_ok_reg     <= iss_hi_ok;
            row_even_reg  <= iss_row_even;
            row_odd_reg   <= iss_row_odd;
        end
        if (res_load) begin
            out_byte_reg  <= res_byte;
            out_entry_reg <= res_entry;
            out_eoc_reg   <= res_eoc;
            out_found_reg <= res_found;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_found_reg, out_eoc_reg, out_entry_reg, out_byte_reg};

endmodule
`default_nettype wire

### rtl/core/fat12_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT12 cluster table engine checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fat12_checker
    import fat12_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or was withdrawn.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid directly after reset.");

    a_found_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> !m_tdata[20] && (m_tdata[7:0] == 8'd0))
        else $error("Free-search result carries fields of another request.");

    a_byte_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] != 8'd0) |-> (m_tdata[19:8] == 12'd0) && !m_tdata[20])
        else $error("Byte result carries entry fields.");

    a_eoc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] && (m_tdata[19:8] != 12'd0) |-> (m_tdata[19:11] == 9'h1FF))
        else $error("End of chain flagged for an ordinary entry.");

endmodule

bind fat12_cluster_table_engine fat12_checker u_fat12_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

### bench/tb_fat12_cluster_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT12 cluster table engine testbench
// Loads part of the table byte by byte, then sends directed and random byte,
// entry and free-search requests across several search window settings.
// A scoreboard predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_fat12_cluster_table_engine;
    import fat12_pkg::*;

    localparam int          PHASES           = 10;
    localparam int          RANDOM_PER_PHASE = 120;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int unsigned LIMIT_CYCLES     = 3_000_000;

    localparam int LOW_REGION_BYTES    = 384;
    localparam int LOW_REGION_CLUSTERS = 256;
    localparam int TOP_REGION_FIRST    = TABLE_BYTES - 24;
    localparam int TOP_CLUSTER_FIRST   = 4080;
    localparam int MAX_CLUSTER         = (1 << CLUSTER_W) - 1;
    localparam int MAX_BYTE_ADDRESS    = (1 << BYTE_ADDR_W) - 1;

    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [ENTRY_W-1:0]     entry_value;
        logic [CLUSTER_W-1:0]   cluster;
        logic [BYTE_W-1:0]      byte_value;
        logic [BYTE_ADDR_W-1:0] byte_address;
    } table_request_t;

    typedef struct packed {
        logic               found_free;
        logic               end_of_chain;
        logic [ENTRY_W-1:0] entry_data;
        logic [BYTE_W-1:0]  byte_data;
    } table_result_t;

    class table_scoreboard;
        logic [BYTE_W-1:0]    table_image [TABLE_BYTES];
        bit                   written [TABLE_BYTES];
        logic [CLUSTER_W-1:0] first_cluster;
        logic [LIMIT_W-1:0]   limit_cluster;
        table_result_t        awaited [$];
        int                   mismatches;
        int                   compared;
        int                   searches_hit;
        int                   per_action [8];

        function new();
            first_cluster = SEARCH_FIRST_RST;
            limit_cluster = SEARCH_LIMIT_RST;
        endfunction

        function void set_search(logic [CLUSTER_W-1:0] first_c, logic [LIMIT_W-1:0] limit_c);
            first_cluster = first_c;
            limit_cluster = limit_c;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [BYTE_W-1:0] byte_at(int addr);
            return (addr < TABLE_BYTES) ? table_image[addr] : '0;
        endfunction

        function void put_byte(int addr, logic [BYTE_W-1:0] value);
            if (addr < TABLE_BYTES) begin
                table_image[addr] = value;
                written[addr]     = 1'b1;
            end
        endfunction

        function logic [ENTRY_W-1:0] entry_at(int c);
            int          off;
            logic [15:0] pair;
            off  = c + c / 2;
            pair = {byte_at(off + 1), byte_at(off)};
            return (c % 2 != 0) ? pair[15:4] : pair[11:0];
        endfunction

        function void put_entry(int c, logic [ENTRY_W-1:0] value);
            int                off;
            logic [BYTE_W-1:0] lo;
            logic [BYTE_W-1:0] hi;
            off = c + c / 2;
            lo  = byte_at(off);
            hi  = byte_at(off + 1);
            if (c % 2 == 0) begin
                lo = value[7:0];
                hi = {hi[7:4], value[11:8]};
            end else begin
                lo = {value[3:0], lo[3:0]};
                hi = value[11:4];
            end
            put_byte(off, lo);
            put_byte(off + 1, hi);
        endfunction

        function bit pair_written(int c);
            int off;
            off = c + c / 2;
            return off + 1 < TABLE_BYTES && written[off] && written[off + 1];
        endfunction

        function int search_end();
            return (limit_cluster < CLUSTER_SPAN) ? int'(limit_cluster) : int'(CLUSTER_SPAN);
        endfunction

        // A search is only sent when every entry it walks over has been written.
        function bit search_safe();
            int c;
            int stop;
            stop = search_end();
            for (c = first_cluster; c < stop; c++) begin
                if (c + c / 2 + 1 >= TABLE_BYTES) return 1'b1;
                if (!pair_written(c)) return 1'b0;
                if (entry_at(c) == '0) return 1'b1;
            end
            return 1'b1;
        endfunction

        function void note_request(table_request_t rq);
            table_result_t r;
            int            c;
            int            stop;
            r = '0;
            per_action[rq.action]++;
            case (rq.action)
                ACT_LOAD_BYTE: put_byte(rq.byte_address, rq.byte_value);
                ACT_READ_BYTE: r.byte_data = byte_at(rq.byte_address);
                ACT_READ_ENTRY: begin
                    r.entry_data   = entry_at(rq.cluster);
                    r.end_of_chain = (r.entry_data == '0) || (r.entry_data >= EOC_LOW);
                end
                ACT_WRITE_ENTRY: put_entry(rq.cluster, rq.entry_value);
                ACT_FIND_FREE: begin
                    stop = search_end();
                    for (c = first_cluster; c < stop; c++) begin
                        if (c + c / 2 + 1 >= TABLE_BYTES) break;
                        if (entry_at(c) == '0) begin
                            r.entry_data = ENTRY_W'(c);
                            r.found_free = 1'b1;
                            searches_hit++;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [ENTRY_W-1:0] want,
                                    logic [ENTRY_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no request outstanding", got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compared++;
            compare_field("byte_data", want.byte_data, got.byte_data);
            compare_field("entry_data", want.entry_data, got.entry_data);
            compare_field("end_of_chain", want.end_of_chain, got.end_of_chain);
            compare_field("found_free", want.found_free, got.found_free);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic [ACTION_W-1:0] s_tuser;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_we;
    logic                cfg_index;
    logic [LIMIT_W-1:0]  cfg_wdata;

    table_scoreboard sb;
    int unsigned     cycle_count = 0;
    int              burst_left  = 0;
    bit              gaps_on     = 1'b1;
    int              hold_asks   = 0;
    int              hold_seen   = 0;
    int              hold_left   = 0;
    int              window_left = 0;
    int              ready_mode  = 0;
    int unsigned     ready_tick  = 0;

    int first_plan [PHASES] = '{3, 0, 4095, 4080, 100, 4095, 10, 200, 0, 3};
    int limit_plan [PHASES] = '{2304, 4096, 4096, 4095, 0, 4095, 20, 256, 0, 2304};

    fat12_cluster_table_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(table_result_t'(m_tdata[21:0]));
        end
    end

    // The receiver stalls in windows of varying pattern, and holds off
    // completely for a long stretch whenever the stimulus asks for it.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (window_left == 0) begin
                    ready_mode  = $urandom_range(0, 3);
                    window_left = $urandom_range(8, 64);
                end
                window_left--;
                ready_tick++;
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= (ready_tick % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    function automatic table_request_t table_request(logic [ACTION_W-1:0] act, int addr,
                                                     int bval, int clus, int ev);
        table_request_t rq;
        rq.action       = act;
        rq.byte_address = BYTE_ADDR_W'(addr);
        rq.byte_value   = BYTE_W'(bval);
        rq.cluster      = CLUSTER_W'(clus);
        rq.entry_value  = ENTRY_W'(ev);
        return rq;
    endfunction

    function automatic int known_byte();
        if ($urandom_range(0, 3) == 0) return $urandom_range(TOP_REGION_FIRST, TABLE_BYTES - 1);
        return $urandom_range(0, LOW_REGION_BYTES - 1);
    endfunction

    function automatic int known_cluster();
        if ($urandom_range(0, 3) == 0) return $urandom_range(TOP_CLUSTER_FIRST, MAX_CLUSTER);
        return $urandom_range(0, LOW_REGION_CLUSTERS - 1);
    endfunction

    function automatic int pick_byte_address();
        case ($urandom_range(0, 7))
            0: return $urandom_range(TABLE_BYTES, MAX_BYTE_ADDRESS);
            1: return $urandom_range(0, TABLE_BYTES - 1);
            2: return ($urandom_range(0, 1) != 0) ? MAX_BYTE_ADDRESS : TABLE_BYTES - 1;
            default: return known_byte();
        endcase
    endfunction

    function automatic int pick_cluster();
        int c;
        case ($urandom_range(0, 7))
            0: c = $urandom_range(0, MAX_CLUSTER);
            1: c = ($urandom_range(0, 1) != 0) ? MAX_CLUSTER : 0;
            default: c = known_cluster();
        endcase
        if (!sb.pair_written(c)) c = known_cluster();
        return c;
    endfunction

    function automatic table_request_t next_request();
        table_request_t rq;
        int             pick;
        int             addr;
        rq.byte_address = BYTE_ADDR_W'($urandom);
        rq.byte_value   = BYTE_W'($urandom);
        rq.cluster      = CLUSTER_W'($urandom);
        rq.entry_value  = ENTRY_W'($urandom);
        pick            = $urandom_range(0, 99);
        if (pick < 15) begin
            rq.action       = ACT_LOAD_BYTE;
            rq.byte_address = BYTE_ADDR_W'(pick_byte_address());
            if ($urandom_range(0, 1) != 0) rq.byte_value = '0;
        end else if (pick < 35) begin
            rq.action = ACT_READ_BYTE;
            addr      = pick_byte_address();
            if (addr < TABLE_BYTES && !sb.written[addr]) addr = known_byte();
            rq.byte_address = BYTE_ADDR_W'(addr);
        end else if (pick < 60) begin
            rq.action  = ACT_READ_ENTRY;
            rq.cluster = CLUSTER_W'(pick_cluster());
        end else if (pick < 80) begin
            rq.action  = ACT_WRITE_ENTRY;
            rq.cluster = CLUSTER_W'(pick_cluster());
            case ($urandom_range(0, 7))
                0, 1: rq.entry_value = '0;
                2: rq.entry_value = ENTRY_W'($urandom_range(12'hFF8, 12'hFFF));
                3: rq.entry_value = 12'hFF7;
                default: ;
            endcase
        end else if (pick < 95) begin
            rq.action = ACT_FIND_FREE;
            if (!sb.search_safe()) begin
                rq.action  = ACT_READ_ENTRY;
                rq.cluster = CLUSTER_W'(known_cluster());
            end
        end else begin
            rq.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return rq;
    endfunction

    task automatic send_request(input table_request_t rq);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= rq.action;
        s_tdata  <= {3'b000, rq.entry_value, rq.cluster, rq.byte_value, rq.byte_address};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_request(rq);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic program_search(input logic [CLUSTER_W-1:0] first_c,
                                  input logic [LIMIT_W-1:0] limit_c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_FIRST;
        cfg_wdata <= LIMIT_W'(first_c);
        @(negedge aclk);
        cfg_index <= CFG_SEARCH_LIMIT;
        cfg_wdata <= limit_c;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_search(first_c, limit_c);
        @(negedge aclk);
    endtask

    initial begin
        int p;
        int a;
        int spare;
        int spare_total;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_LOAD_BYTE;
        cfg_we    = 1'b0;
        cfg_index = CFG_SEARCH_FIRST;
        cfg_wdata = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (p = 0; p < PHASES; p++) begin
            if (p == 8) begin
                first_plan[p] = $urandom_range(0, LOW_REGION_CLUSTERS - 1);
                limit_plan[p] = $urandom_range(0, CLUSTER_SPAN);
            end
            if (p > 0) begin
                wait_drained();
                program_search(CLUSTER_W'(first_plan[p]), LIMIT_W'(limit_plan[p]));
            end
            gaps_on = (p % 3 != 2);

            if (p == 0) begin
                // Every entry read or searched later must sit on loaded bytes.
                for (a = 0; a < LOW_REGION_BYTES; a++)
                    send_request(table_request(ACT_LOAD_BYTE, a,
                        ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255), 0, 0));
                for (a = TOP_REGION_FIRST; a < TABLE_BYTES; a++)
                    send_request(table_request(ACT_LOAD_BYTE, a,
                        ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255), 0, 0));

                send_request(table_request(ACT_LOAD_BYTE, TABLE_BYTES - 1, 8'hFF, 0, 0));
                send_request(table_request(ACT_LOAD_BYTE, MAX_BYTE_ADDRESS, 8'hA5, 0, 0));
                send_request(table_request(ACT_READ_BYTE, MAX_BYTE_ADDRESS, 0, 0, 0));
                send_request(table_request(ACT_READ_BYTE, TABLE_BYTES, 0, 0, 0));
                send_request(table_request(ACT_READ_BYTE, TABLE_BYTES - 1, 0, 0, 0));
                send_request(table_request(ACT_READ_BYTE, 0, 0, 0, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 0, 12'hFFF));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, 0, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 1, 12'hFF8));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, 1, 0));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, 0, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 2, 0));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, 2, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 3, 12'hFF7));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, 3, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 4, 0));
                send_request(table_request(ACT_FIND_FREE, 0, 0, 0, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, MAX_CLUSTER, 12'hABC));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, MAX_CLUSTER - 1, 0));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, MAX_CLUSTER, 0));
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, MAX_CLUSTER - 1, 12'h123));
                send_request(table_request(ACT_READ_ENTRY, 0, 0, MAX_CLUSTER, 0));
                for (spare = ACT_SPARE_FIRST; spare <= ACT_SPARE_LAST; spare++)
                    send_request(table_request(ACTION_W'(spare), MAX_BYTE_ADDRESS, 8'hFF,
                                               MAX_CLUSTER, 12'hFFF));
            end

            if (p == 1) begin
                send_request(table_request(ACT_WRITE_ENTRY, 0, 0, 0, 0));
                send_request(table_request(ACT_FIND_FREE, 0, 0, 0, 0));
            end

            if (p == 2 || p == 6) hold_asks++;

            repeat (RANDOM_PER_PHASE) send_request(next_request());
        end

        wait_drained();

        spare_total = 0;
        for (spare = ACT_SPARE_FIRST; spare <= ACT_SPARE_LAST; spare++)
            spare_total += sb.per_action[spare];

        $display("Covered %0d byte loads, %0d byte reads, %0d entry reads, %0d entry writes,",
                 sb.per_action[ACT_LOAD_BYTE], sb.per_action[ACT_READ_BYTE],
                 sb.per_action[ACT_READ_ENTRY], sb.per_action[ACT_WRITE_ENTRY]);
        $display("%0d free searches (%0d hits), %0d spare codes, %0d windows, %0d compared.",
                 sb.per_action[ACT_FIND_FREE], sb.searches_hit,
                 spare_total, PHASES, sb.compared);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
